// File: rtl/crc10pec_pkg.sv
// Shared constants, types and CRC step functions for the CRC-10 PEC block.
`timescale 1ns / 1ps
package crc10pec_pkg;

    localparam int CRC_W = 10;
    localparam int BYTE_W = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int COUNTER_STEPS = 6;
    localparam logic [CRC_W-1:0] CRC_FEEDBACK = 10'h08F;
    localparam logic [BYTE_W-1:0] COUNTER_MASK = 8'hFC;
    localparam logic [CRC_W-1:0] SEED_RESET = 10'd16;
    localparam logic [0:0] REG_CRC_SEED = 1'b0;

    typedef struct packed {
        logic             load;
        logic [CRC_W-1:0] seed;
    } cfg_ctl_t;

    function automatic logic [CRC_W-1:0] bit_step(input logic [CRC_W-1:0] c);
        logic [CRC_W-1:0] n;
        n = {c[CRC_W-2:0], 1'b0};
        if (c[CRC_W-1])
        begin
            n = n ^ CRC_FEEDBACK;
        end
        return n;
    endfunction

    function automatic logic [CRC_W-1:0] byte_step(input logic [CRC_W-1:0] c,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {b, 2'b00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            r = bit_step(r);
        end
        return r;
    endfunction

endpackage

// File: rtl/crc10_pec_with_command_counter_core.sv
// Top level of the CRC-10 packet error code block with command-counter tail.
//
// Input channel: one message byte per item (data_byte, last_byte, receive_mode,
// tail_byte), taken at a clock edge with in_valid high and in_stall low.
// Output channel: one pec_value item per message, given with out_valid and held
// while out_stall is high.
// A last byte accepted passes through the input register to the result register.
// Throughput: one item per cycle, but for a held last byte; the input register
// feeds a combinational CRC update (eight bit steps, plus six tail steps on the
// last byte) into the running CRC register and the result register.
// When the receiver stalls, non-last bytes keep flowing; a last byte waits in
// the input register and in_stall rises until the result register frees.
// Reset clears both valids, sets the seed to 16 and loads it into the running
// CRC. Writing the seed over APB also reloads the running CRC, restarting any
// message in progress. pready is always high; prdata returns the seed.
`timescale 1ns / 1ps
module crc10_pec_with_command_counter_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [crc10pec_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [crc10pec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [crc10pec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [crc10pec_pkg::BYTE_W-1:0]        data_byte,
    input  logic                                   last_byte,
    input  logic                                   receive_mode,
    input  logic [crc10pec_pkg::BYTE_W-1:0]        tail_byte,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [crc10pec_pkg::CRC_W-1:0]         pec_value
);

    crc10pec_pkg::cfg_ctl_t cfg_ctl;

    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic [crc10pec_pkg::BYTE_W-1:0]   s1_data_reg;
    logic                              s1_last_reg;
    logic                              s1_recv_reg;
    logic [crc10pec_pkg::BYTE_W-1:0]   s1_tail_reg;
    logic                              s1_advance;
    logic                              in_take;

    logic [crc10pec_pkg::CRC_W-1:0]    acc_reg;
    logic [crc10pec_pkg::CRC_W-1:0]    acc_next;
    logic [crc10pec_pkg::CRC_W-1:0]    crc_byte;
    logic [crc10pec_pkg::CRC_W-1:0]    crc_pec;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [crc10pec_pkg::CRC_W-1:0]    pec_reg;
    logic                              out_load;

    crc10pec_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_ctl (cfg_ctl)
    );

    crc10pec_engine u_engine
    (
        .acc          (acc_reg),
        .data_byte    (s1_data_reg),
        .receive_mode (s1_recv_reg),
        .tail_byte    (s1_tail_reg),
        .crc_out      (crc_byte),
        .pec_out      (crc_pec)
    );

    // hold a last byte while the result register is full and stalled
    assign s1_advance = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_take    = in_valid && !in_stall;
    assign out_load   = s1_advance && s1_last_reg;

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        if (cfg_ctl.load)
        begin
            acc_next = cfg_ctl.seed;
        end
        else if (s1_advance)
        begin
            acc_next = s1_last_reg ? cfg_ctl.seed : crc_byte;
        end
        else
        begin
            acc_next = acc_reg;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= crc10pec_pkg::SEED_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
            s1_recv_reg <= receive_mode;
            s1_tail_reg <= tail_byte;
        end
        if (out_load)
        begin
            pec_reg <= crc_pec;
        end
    end

    assign out_valid = out_valid_reg;
    assign pec_value = pec_reg;

endmodule

// File: rtl/crc10pec_cfg.sv
// APB register file holding the CRC seed.
`timescale 1ns / 1ps
module crc10pec_cfg
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [crc10pec_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [crc10pec_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [crc10pec_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output crc10pec_pkg::cfg_ctl_t                 cfg_ctl
);

    logic                            seed_wr;
    logic [crc10pec_pkg::CRC_W-1:0]  seed_reg;
    logic [crc10pec_pkg::CRC_W-1:0]  seed_next;

    assign seed_wr = psel && penable && pwrite
                     && (paddr[crc10pec_pkg::APB_ADDR_W-1:2] == crc10pec_pkg::REG_CRC_SEED);
    assign seed_next = seed_wr ? pwdata[crc10pec_pkg::CRC_W-1:0] : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= crc10pec_pkg::SEED_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = {{(crc10pec_pkg::APB_DATA_W-crc10pec_pkg::CRC_W){1'b0}}, seed_reg};
    assign cfg_ctl.load = seed_wr;
    assign cfg_ctl.seed = seed_wr ? pwdata[crc10pec_pkg::CRC_W-1:0] : seed_reg;

endmodule

// File: rtl/crc10pec_engine.sv
// Combinational CRC-10 byte update and command-counter tail fold.
`timescale 1ns / 1ps
module crc10pec_engine
(
    input  logic [crc10pec_pkg::CRC_W-1:0]  acc,
    input  logic [crc10pec_pkg::BYTE_W-1:0] data_byte,
    input  logic                            receive_mode,
    input  logic [crc10pec_pkg::BYTE_W-1:0] tail_byte,
    output logic [crc10pec_pkg::CRC_W-1:0]  crc_out,
    output logic [crc10pec_pkg::CRC_W-1:0]  pec_out
);

    logic [crc10pec_pkg::BYTE_W-1:0] counter;
    logic [crc10pec_pkg::CRC_W-1:0]  tail_crc;

    always_comb
    begin
        crc_out  = crc10pec_pkg::byte_step(acc, data_byte);
        counter  = receive_mode ? (tail_byte & crc10pec_pkg::COUNTER_MASK)
                                : {crc10pec_pkg::BYTE_W{1'b0}};
        tail_crc = crc_out ^ {counter, 2'b00};
        for (int i = 0; i < crc10pec_pkg::COUNTER_STEPS; i++)
        begin
            tail_crc = crc10pec_pkg::bit_step(tail_crc);
        end
        pec_out = tail_crc;
    end

endmodule

// File: rtl/crc10pec_checker.sv
// Port-level assertions for the CRC-10 PEC block, bound to the top level.
`timescale 1ns / 1ps
module crc10pec_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [crc10pec_pkg::APB_ADDR_W-1:0] paddr,
    input logic [crc10pec_pkg::APB_DATA_W-1:0] pwdata,
    input logic [crc10pec_pkg::APB_DATA_W-1:0] prdata,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                last_byte,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [crc10pec_pkg::CRC_W-1:0]      pec_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pec_value))
        else $error("stalled result changed or dropped");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last_byte, 2))
        else $error("result appeared without a last byte two cycles earlier");

    a_seed_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite
        && (paddr[crc10pec_pkg::APB_ADDR_W-1:2] == crc10pec_pkg::REG_CRC_SEED)
        |=> prdata[crc10pec_pkg::CRC_W-1:0] == $past(pwdata[crc10pec_pkg::CRC_W-1:0])
            && prdata[crc10pec_pkg::APB_DATA_W-1:crc10pec_pkg::CRC_W] == '0)
        else $error("seed readback mismatch");

endmodule

bind crc10_pec_with_command_counter_core crc10pec_checker u_crc10pec_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pec_value (pec_value)
);
